FILE: src/cct_pkg.sv
// shared types and constants for the csma/cd contention tick block
// no dependencies; every other file imports this package
package cct_pkg;

    localparam int NODES       = 8;
    localparam int EXP_BITS    = 7;
    localparam int RAND_STRIDE = 7;
    localparam int NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;

    localparam int RAND_W    = 56;
    localparam int SEL_W     = 3;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 32;
    localparam int BACKOFF_W = 15;
    localparam int ATTEMPT_W = 3;
    localparam int NCOUNT_W  = 4;
    localparam int FRAME_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [NCOUNT_W-1:0]  NODE_COUNT_RST   = NCOUNT_W'(5);
    localparam logic [ATTEMPT_W-1:0] MAX_EXPONENT_RST = ATTEMPT_W'(5);
    localparam logic [FRAME_W-1:0]   FRAME_LENGTH_RST = FRAME_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT   = 2'd0,
        CFG_MAX_EXPONENT = 2'd1,
        CFG_FRAME_LENGTH = 2'd2
    } cfg_index_t;

    // per-lane control from the channel logic
    typedef struct packed {
        logic                  step;
        logic                  active;
        logic                  is_owner;
        logic                  owned;
        logic                  collide;
        logic                  finish;
        logic [EXP_BITS-1:0]   rnd;
        logic [ATTEMPT_W-1:0]  max_exp;
        logic [FRAME_W-1:0]    frame;
    } node_ctl_t;

    // per-lane status back to the channel logic
    typedef struct packed {
        logic              contend;
        logic              defer;
        logic [CNT_W-1:0]  successes;
        logic [CNT_W-1:0]  collisions;
        logic [CNT_W-1:0]  backoffs;
    } node_stat_t;

    typedef struct packed {
        logic              channel_busy;
        logic [2:0]        owner_node;
        logic              frame_done;
        logic              collision;
        logic [MASK_W-1:0] collided_mask;
        logic [MASK_W-1:0] deferred_mask;
        logic [CNT_W-1:0]  sel_successes;
        logic [CNT_W-1:0]  sel_collisions;
        logic [CNT_W-1:0]  sel_backoffs;
    } result_t;

endpackage

FILE: src/cct_stream_if.sv
// valid/ready channel interfaces: tick input, result output, config write
// depends on cct_pkg for field widths
interface cct_tick_if
    import cct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RAND_W-1:0] random_bits;
    logic [SEL_W-1:0]  node_select;

    modport source (output valid, output random_bits, output node_select, input ready);
    modport sink   (input valid, input random_bits, input node_select, output ready);
endinterface

interface cct_result_if
    import cct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              channel_busy;
    logic [2:0]        owner_node;
    logic              frame_done;
    logic              collision;
    logic [MASK_W-1:0] collided_mask;
    logic [MASK_W-1:0] deferred_mask;
    logic [CNT_W-1:0]  sel_successes;
    logic [CNT_W-1:0]  sel_collisions;
    logic [CNT_W-1:0]  sel_backoffs;

    modport source (output valid, output channel_busy, output owner_node, output frame_done,
                    output collision, output collided_mask, output deferred_mask,
                    output sel_successes, output sel_collisions, output sel_backoffs,
                    input ready);
    modport sink   (input valid, input channel_busy, input owner_node, input frame_done,
                    input collision, input collided_mask, input deferred_mask,
                    input sel_successes, input sel_collisions, input sel_backoffs,
                    output ready);
endinterface

interface cct_cfg_if
    import cct_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cct_node.sv
// one node lane: backoff countdown, attempt count and statistic counters
// depends on cct_pkg for node_ctl_t and node_stat_t
module cct_node
    import cct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  node_ctl_t  ctl,
    output node_stat_t stat
);

    logic [BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic [ATTEMPT_W-1:0] attempt_reg, attempt_next;
    logic [CNT_W-1:0]     succ_reg, succ_next;
    logic [CNT_W-1:0]     coll_reg, coll_next;
    logic [CNT_W-1:0]     boff_reg, boff_next;

    logic                         skip_lane;
    logic                         counting;
    logic                         do_backoff;
    logic [ATTEMPT_W-1:0]         attempt_inc;
    logic [ATTEMPT_W-1:0]         exp_val;
    logic [EXP_BITS-1:0]          slot_mask;
    logic [EXP_BITS-1:0]          slot_k;
    logic [EXP_BITS+FRAME_W-1:0]  slot_prod;

    assign skip_lane = !ctl.active || ctl.is_owner;
    assign counting  = (backoff_reg != '0);

    assign stat.contend = !skip_lane && !counting && !ctl.owned;
    assign stat.defer   = !skip_lane && !counting && ctl.owned;
    assign do_backoff   = stat.defer || (stat.contend && ctl.collide);

    always_comb
    begin
        attempt_inc = (attempt_reg < ctl.max_exp) ? attempt_reg + 1'b1 : attempt_reg;
        exp_val     = (attempt_inc > ctl.max_exp) ? ctl.max_exp : attempt_inc;
        if (int'(exp_val) > EXP_BITS)
        begin
            exp_val = ATTEMPT_W'(EXP_BITS);
        end
    end

    assign slot_mask = ~({EXP_BITS{1'b1}} << exp_val);
    assign slot_k    = ctl.rnd & slot_mask;
    assign slot_prod = (EXP_BITS+FRAME_W)'(slot_k) * (EXP_BITS+FRAME_W)'(ctl.frame);

    always_comb
    begin
        backoff_next = backoff_reg;
        attempt_next = attempt_reg;
        succ_next    = succ_reg;
        coll_next    = coll_reg;
        boff_next    = boff_reg;
        priority if (ctl.finish)
        begin
            backoff_next = '0;
            attempt_next = '0;
            succ_next    = succ_reg + 1'b1;
        end
        else if (do_backoff)
        begin
            attempt_next = attempt_inc;
            backoff_next = BACKOFF_W'(slot_prod);
            boff_next    = boff_reg + 1'b1;
            if (stat.contend)
            begin
                coll_next = coll_reg + 1'b1;
            end
        end
        else if (!skip_lane && counting)
        begin
            backoff_next = backoff_reg - 1'b1;
        end
    end

    assign stat.successes  = succ_next;
    assign stat.collisions = coll_next;
    assign stat.backoffs   = boff_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backoff_reg <= '0;
            attempt_reg <= '0;
            succ_reg    <= '0;
            coll_reg    <= '0;
            boff_reg    <= '0;
        end
        else if (ctl.step)
        begin
            backoff_reg <= backoff_next;
            attempt_reg <= attempt_next;
            succ_reg    <= succ_next;
            coll_reg    <= coll_next;
            boff_reg    <= boff_next;
        end
    end

    // a lane never backs off while it is waiting out a countdown
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && counting) |-> !do_backoff)
        else $error("lane backed off during countdown");

    // the finishing transmitter is never also backing off
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && ctl.finish) |-> !do_backoff)
        else $error("finishing lane backed off");

    // inactive lanes and the current owner take no part in contention
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && skip_lane) |-> !(stat.contend || stat.defer))
        else $error("skipped lane contended or deferred");

endmodule

FILE: src/csma_cd_contention_tick.sv
// top level of the csma/cd contention tick block: config registers, input word
// register, channel owner logic, node lanes and result register
// depends on cct_pkg, cct_stream_if.sv and cct_node
// the input register feeds the combinational lanes and channel logic, which
// feed the result register; one tick word per cycle while results are taken
// the result register and input register let a new word in while a result waits
// reset: all lane state, owner and counters cleared; node_count 5, max_exponent 5,
// frame_length 4; no clearing pass, words are taken right after reset
module csma_cd_contention_tick
    import cct_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    cct_tick_if.sink    tick_in,
    cct_result_if.source result_out,
    cct_cfg_if.sink     cfg
);

    // configuration
    logic [NCOUNT_W-1:0]  node_count_reg;
    logic [ATTEMPT_W-1:0] max_exp_reg;
    logic [FRAME_W-1:0]   frame_len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            max_exp_reg    <= MAX_EXPONENT_RST;
            frame_len_reg  <= FRAME_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_NODE_COUNT:   node_count_reg <= NCOUNT_W'(cfg.data);
                CFG_MAX_EXPONENT: max_exp_reg    <= ATTEMPT_W'(cfg.data);
                CFG_FRAME_LENGTH: frame_len_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // input word register and handshake
    logic              in_valid_reg;
    logic [RAND_W-1:0] in_rand_reg;
    logic [SEL_W-1:0]  in_sel_reg;
    logic              out_valid_reg;
    result_t           out_reg, out_next;
    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign tick_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_in.ready)
        begin
            in_valid_reg <= tick_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_in.valid && tick_in.ready)
        begin
            in_rand_reg <= tick_in.random_bits;
            in_sel_reg  <= tick_in.node_select;
        end
    end

    // channel state
    logic              owned_reg, owned_next;
    logic [NODE_W-1:0] owner_reg, owner_next;
    logic [FRAME_W-1:0] remain_reg, remain_next;

    logic [FRAME_W-1:0] eff_frame;
    node_ctl_t          ctl [NODES];
    node_stat_t         stat [NODES];
    logic [NODES-1:0]   contend_vec;
    logic [NODES-1:0]   defer_vec;
    logic               collide;
    logic               single;
    logic [NODE_W-1:0]  last_idx;
    logic               mid_owned;
    logic [FRAME_W-1:0] mid_remain;
    logic [FRAME_W-1:0] remain_dec;
    logic               done;

    assign eff_frame = (frame_len_reg == '0) ? FRAME_W'(1) : frame_len_reg;

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            contend_vec[i] = stat[i].contend;
            defer_vec[i]   = stat[i].defer;
        end
    end

    assign collide = ($countones(contend_vec) > 1);
    assign single  = ($countones(contend_vec) == 1);

    // index of the lone contender
    always_comb
    begin
        last_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (contend_vec[i])
            begin
                last_idx = last_idx | NODE_W'(i);
            end
        end
    end

    always_comb
    begin
        mid_owned   = owned_reg || single;
        owner_next  = single ? last_idx : owner_reg;
        mid_remain  = single ? eff_frame : remain_reg;
        remain_dec  = mid_remain - 1'b1;
        done        = mid_owned && (remain_dec == '0);
        owned_next  = mid_owned && !done;
        remain_next = mid_owned ? remain_dec : remain_reg;
    end

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            ctl[i].step     = advance;
            ctl[i].active   = (NCOUNT_W'(i) < node_count_reg);
            ctl[i].is_owner = owned_reg && (owner_reg == NODE_W'(i));
            ctl[i].owned    = owned_reg;
            ctl[i].collide  = collide;
            ctl[i].finish   = done && (owner_next == NODE_W'(i));
            ctl[i].rnd      = in_rand_reg[RAND_STRIDE*i +: EXP_BITS];
            ctl[i].max_exp  = max_exp_reg;
            ctl[i].frame    = eff_frame;
        end
    end

    for (genvar g = 0; g < NODES; g++)
    begin : g_lane
        cct_node u_node (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[g]),
            .stat  (stat[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg  <= 1'b0;
            owner_reg  <= '0;
            remain_reg <= '0;
        end
        else if (advance)
        begin
            owned_reg  <= owned_next;
            owner_reg  <= owner_next;
            remain_reg <= remain_next;
        end
    end

    // result word
    always_comb
    begin
        out_next               = '0;
        out_next.channel_busy  = owned_next;
        out_next.owner_node    = mid_owned ? 3'(owner_next) : 3'd0;
        out_next.frame_done    = done;
        out_next.collision     = collide;
        out_next.collided_mask = collide ? MASK_W'(contend_vec) : '0;
        out_next.deferred_mask = MASK_W'(defer_vec);
        if (int'(in_sel_reg) < NODES)
        begin
            out_next.sel_successes  = stat[in_sel_reg[NODE_W-1:0]].successes;
            out_next.sel_collisions = stat[in_sel_reg[NODE_W-1:0]].collisions;
            out_next.sel_backoffs   = stat[in_sel_reg[NODE_W-1:0]].backoffs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.channel_busy   = out_reg.channel_busy;
    assign result_out.owner_node     = out_reg.owner_node;
    assign result_out.frame_done     = out_reg.frame_done;
    assign result_out.collision      = out_reg.collision;
    assign result_out.collided_mask  = out_reg.collided_mask;
    assign result_out.deferred_mask  = out_reg.deferred_mask;
    assign result_out.sel_successes  = out_reg.sel_successes;
    assign result_out.sel_collisions = out_reg.sel_collisions;
    assign result_out.sel_backoffs   = out_reg.sel_backoffs;

    // an owned channel always has frame ticks left
    assert property (@(posedge clk) disable iff (!rst_n)
        owned_reg |-> (remain_reg != '0))
        else $error("channel owned with no frame ticks left");

    // deferring needs a busy channel, colliding an idle one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !((out_reg.collided_mask != '0) && (out_reg.deferred_mask != '0)))
        else $error("collision and deferral in the same tick");

    // collision flag matches the collided lanes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.collision == ($countones(out_reg.collided_mask) > 1)))
        else $error("collision flag disagrees with collided mask");

    // a finished frame releases the channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_done) |-> !out_reg.channel_busy)
        else $error("channel still busy after frame done");

    // a held tick word stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled tick word dropped");

endmodule
